// ===== rtl/frpg_pkg.sv =====
// ----------------------------------------------------------------------------
// frpg_pkg
// Shared constants and types of the fractal raster pixel generator.
// ----------------------------------------------------------------------------
package frpg_pkg;

  // Number of digit cells, one per recursion level
  localparam int unsigned MaxLevel = 6;
  localparam int unsigned DigitW   = 2;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;

  // Pattern modes; the unused code falls back to the carpet rule
  localparam logic [ModeW-1:0] ModeCarpet   = 2'd0;
  localparam logic [ModeW-1:0] ModeTriangle = 2'd1;
  localparam logic [ModeW-1:0] ModeVicsek   = 2'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPatternMode = 2'd0,
    RegLevel       = 2'd1
  } cfg_reg_e;

  // Digit values
  localparam logic [DigitW-1:0] DigitZero = 2'd0;
  localparam logic [DigitW-1:0] DigitOne  = 2'd1;
  localparam logic [DigitW-1:0] DigitTwo  = 2'd2;

  // Control common to every cell
  typedef struct packed {
    logic base_two;  // base 2 instead of base 3
    logic vicsek;    // corner/center rule instead of hole rule
    logic restart;   // scan returns to origin for this beat
    logic step;      // a beat is accepted, digits advance
    logic clear;     // register write, digits return to zero
  } cell_ctl_t;

  // Data handed from one cell to the next level up
  typedef struct packed {
    logic col_carry;  // column counter wraps below this level
    logic row_carry;  // row counter wraps below this level
    logic fill;       // every lower level allows its digit pair
  } cell_link_t;

  // One result beat
  typedef struct packed {
    logic filled;
    logic row_end;
    logic frame_end;
  } pix_t;

endpackage

// ===== rtl/frpg_cell.sv =====
// ----------------------------------------------------------------------------
// frpg_cell
// One recursion level: holds the row and column digit of that level, checks
// the digit pair and passes the carries and fill flag to the next level.
// ----------------------------------------------------------------------------
module frpg_cell
  import frpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       active_i,
  input  cell_ctl_t  ctl_i,
  input  cell_link_t link_i,
  output cell_link_t link_o
);

  logic [DigitW-1:0] row_q, row_d;
  logic [DigitW-1:0] col_q, col_d;
  logic [DigitW-1:0] row_eff, col_eff;
  logic              row_top, col_top;
  logic              pair_ok;
  logic              row_inc, col_inc;

  // Restart clears the digits before they are looked at
  assign row_eff = ctl_i.restart ? DigitZero : row_q;
  assign col_eff = ctl_i.restart ? DigitZero : col_q;

  // Top digit of the base
  assign row_top = ctl_i.base_two ? (row_eff != DigitZero) : (row_eff >= DigitTwo);
  assign col_top = ctl_i.base_two ? (col_eff != DigitZero) : (col_eff >= DigitTwo);

  // Allowed digit pair
  always_comb begin
    if (ctl_i.vicsek) begin
      pair_ok = ((row_eff != DigitOne) && (col_eff != DigitOne)) ||
                ((row_eff == DigitOne) && (col_eff == DigitOne));
    end else begin
      pair_ok = !((row_eff == DigitOne) && (col_eff == DigitOne));
    end
  end

  // Carry and fill chain; an inactive level is transparent
  assign col_inc = active_i && link_i.col_carry;
  assign row_inc = active_i && link_i.row_carry;

  assign link_o.col_carry = link_i.col_carry && (!active_i || col_top);
  assign link_o.row_carry = link_i.row_carry && (!active_i || row_top);
  assign link_o.fill      = link_i.fill && (!active_i || pair_ok);

  // Next digits
  always_comb begin
    col_d = col_eff;
    row_d = row_eff;
    if (col_inc) begin
      col_d = col_top ? DigitZero : col_eff + DigitOne;
    end
    if (row_inc) begin
      row_d = row_top ? DigitZero : row_eff + DigitOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= DigitZero;
      col_q <= DigitZero;
    end else if (ctl_i.clear) begin
      row_q <= DigitZero;
      col_q <= DigitZero;
    end else if (ctl_i.step) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== rtl/fractal_raster_pixel_generator_top.sv =====
// Each pixel beat is registered in the output register, or first in the skid
// entry while the output is held. One pixel per cycle while the skid entry is
// empty; the carry chain through the MaxLevel cells is combinational, and a
// two-entry output stage keeps input ready while one result waits. Reset:
// asynchronous, active low; scan to origin, mode carpet, level 1, output empty.
// ----------------------------------------------------------------------------
// fractal_raster_pixel_generator_top
// Raster scan of carpet, triangle or Vicsek patterns over a row of digit cells.
// ----------------------------------------------------------------------------
module fractal_raster_pixel_generator_top
  import frpg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                filled_o,
  output logic                row_end_o,
  output logic                frame_end_o
);

  localparam int unsigned LvlCntW = $clog2(MaxLevel + 1);

  logic [ModeW-1:0]  mode_q;
  logic [LevelW-1:0] level_q;
  logic              cfg_hit;
  logic [LvlCntW-1:0] lvl_eff;
  logic [MaxLevel-1:0] active;
  logic              in_beat;
  cell_ctl_t         ctl;
  cell_link_t        link [MaxLevel+1];
  pix_t              pix;
  pix_t              out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  // Configuration registers
  assign cfg_hit = cfg_we_i &&
                   ((cfg_idx_i == RegPatternMode) || (cfg_idx_i == RegLevel));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeCarpet;
      level_q <= LevelW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPatternMode: mode_q  <= cfg_wdata_i[ModeW-1:0];
        RegLevel:       level_q <= cfg_wdata_i[LevelW-1:0];
        default:        ;
      endcase
    end
  end

  // Active level count, clamped to 1..MaxLevel
  always_comb begin
    if (level_q == '0) begin
      lvl_eff = LvlCntW'(1);
    end else if (32'(level_q) > MaxLevel) begin
      lvl_eff = LvlCntW'(MaxLevel);
    end else begin
      lvl_eff = LvlCntW'(level_q);
    end
  end

  for (genvar k = 0; k < MaxLevel; k++) begin : g_active
    assign active[k] = (LvlCntW'(k) < lvl_eff);
  end

  // Cell control
  assign in_beat      = in_valid_i && in_ready_o;
  assign ctl.base_two = (mode_q == ModeTriangle);
  assign ctl.vicsek   = (mode_q == ModeVicsek);
  assign ctl.restart  = restart_i;
  assign ctl.step     = in_beat;
  assign ctl.clear    = cfg_hit;

  // Row of digit cells; the column carry out of the top feeds the row counter
  assign link[0].col_carry = 1'b1;
  assign link[0].row_carry = link[MaxLevel].col_carry;
  assign link[0].fill      = 1'b1;

  for (genvar k = 0; k < MaxLevel; k++) begin : g_cell
    frpg_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active[k]),
      .ctl_i    (ctl),
      .link_i   (link[k]),
      .link_o   (link[k+1])
    );
  end

  assign pix.filled    = link[MaxLevel].fill;
  assign pix.row_end   = link[MaxLevel].col_carry;
  assign pix.frame_end = link[MaxLevel].row_carry;

  // Output register with skid entry
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_beat;
      end
    end else if (in_beat) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_beat) begin
        out_q <= pix;
      end
    end else if (in_beat) begin
      skid_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filled_o    = out_q.filled;
  assign row_end_o   = out_q.row_end;
  assign frame_end_o = out_q.frame_end;

`ifndef SYNTH
  // Frame end only ever comes on the last pixel of a row
  a_frame_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!frame_end_o || row_end_o))
    else $error("frame_end without row_end");

  // Skid entry is only filled behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // A restarted beat is the first pixel of a row and cannot end it
  a_restart_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && restart_i) |-> !pix.row_end)
    else $error("restart beat marked as row end");
`endif

endmodule

// ===== dv/fractal_raster_pixel_generator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fractal_raster_pixel_generator_top_tb
// Self-checking bench for the fractal raster pixel generator. Pixel ticks go
// in over a valid/ready channel, with random restarts, under several idle and
// stall mixes. A local scan model predicts every pixel beat (filled, row end,
// frame end) from its own digit counters, and each output beat is checked
// against the oldest prediction. Pattern and level are rewritten between
// bursts, including the unused mode, level zero, a level above the maximum
// and writes to indexes past the register list.
// ----------------------------------------------------------------------------
module fractal_raster_pixel_generator_top_tb;
  import frpg_pkg::*;

  // Mode code with no pattern of its own, indexes past the register list
  localparam logic [ModeW-1:0]   ModeUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 2'd2;

  // Idle mixes
  localparam int unsigned StyleFree      = 0;
  localparam int unsigned StyleSendIdle  = 1;
  localparam int unsigned StyleRecvStall = 2;
  localparam int unsigned StyleBoth      = 3;

  // Cycles without any beat or write before the run is declared hung
  localparam int unsigned QuietLimit = 1000;

  // Scan model: digit counters, registers and the pixels still owed
  class raster_scan_model;
    logic [DigitW-1:0] row_dig [MaxLevel];
    logic [DigitW-1:0] col_dig [MaxLevel];
    logic [ModeW-1:0]  mode;
    logic [LevelW-1:0] lvl;
    pix_t              owed_pixels [$];
    int unsigned       errors;

    function new();
      mode   = ModeCarpet;
      lvl    = LevelW'(1);
      errors = 0;
      home();
    endfunction

    function void home();
      for (int k = 0; k < MaxLevel; k++) begin
        row_dig[k] = DigitZero;
        col_dig[k] = DigitZero;
      end
    endfunction

    function int unsigned pending();
      return owed_pixels.size();
    endfunction

    // Any write to a listed register also sends the scan home
    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegPatternMode: begin
          mode = data[ModeW-1:0];
          home();
        end
        RegLevel: begin
          lvl = data;
          home();
        end
        default: ;
      endcase
    endfunction

    // Vicsek keeps corners and center; the others punch out the center
    function bit pair_ok(logic [DigitW-1:0] r, logic [DigitW-1:0] c);
      if (mode == ModeVicsek)
        return (r != DigitOne && c != DigitOne) || (r == DigitOne && c == DigitOne);
      return !(r == DigitOne && c == DigitOne);
    endfunction

    function void take_tick(logic restart);
      int unsigned levels;
      int unsigned base;
      bit          carry;
      pix_t        px;
      levels = (lvl == 0) ? 1 : ((lvl > MaxLevel) ? MaxLevel : int'(lvl));
      base   = (mode == ModeTriangle) ? 2 : 3;
      if (restart) home();

      // pixel flags from the current position
      px.filled    = 1'b1;
      px.row_end   = 1'b1;
      px.frame_end = 1'b1;
      for (int k = 0; k < levels; k++) begin
        if (!pair_ok(row_dig[k], col_dig[k])) px.filled = 1'b0;
        if (int'(col_dig[k]) + 1 < base) px.row_end = 1'b0;
        if (int'(row_dig[k]) + 1 < base) px.frame_end = 1'b0;
      end
      px.frame_end = px.frame_end & px.row_end;

      // column counter; its carry out moves the row counter
      carry = 1'b1;
      for (int k = 0; k < levels; k++) begin
        if (carry) begin
          if (int'(col_dig[k]) + 1 >= base) begin
            col_dig[k] = DigitZero;
          end else begin
            col_dig[k] = col_dig[k] + DigitOne;
            carry = 1'b0;
          end
        end
      end
      for (int k = 0; k < levels; k++) begin
        if (carry) begin
          if (int'(row_dig[k]) + 1 >= base) begin
            row_dig[k] = DigitZero;
          end else begin
            row_dig[k] = row_dig[k] + DigitOne;
            carry = 1'b0;
          end
        end
      end
      owed_pixels.push_back(px);
    endfunction

    function void check_pixel(pix_t got);
      pix_t want;
      if (owed_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel beat with nothing expected: filled=%b row_end=%b frame_end=%b",
                 $time, got.filled, got.row_end, got.frame_end);
        return;
      end
      want = owed_pixels.pop_front();
      if (got.filled !== want.filled) begin
        errors++;
        $display("%0t: filled expected %b, got %b", $time, want.filled, got.filled);
      end
      if (got.row_end !== want.row_end) begin
        errors++;
        $display("%0t: row_end expected %b, got %b", $time, want.row_end, got.row_end);
      end
      if (got.frame_end !== want.frame_end) begin
        errors++;
        $display("%0t: frame_end expected %b, got %b", $time, want.frame_end,
                 got.frame_end);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                restart_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                filled_o;
  logic                row_end_o;
  logic                frame_end_o;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  raster_scan_model scan = new();

  fractal_raster_pixel_generator_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filled_o    (filled_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  always #1 clk_i = ~clk_i;

  // Output backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Beat monitor, model update and hang watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) scan.apply_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_o) scan.take_tick(restart_i);
      if (out_valid_o && out_ready_i)
        scan.check_pixel(pix_t'({filled_o, row_end_o, frame_end_o}));
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // One tick beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic restart);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait for every owed pixel
  task automatic end_burst();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (scan.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic cfg_idle();
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CfgDataW-1:0] mode_wd,
                           input logic [CfgDataW-1:0] level_wd,
                           input int unsigned n_items, input int unsigned style);
    case (style)
      StyleSendIdle:  begin send_idle_pct = 65; recv_stall_pct = 0;  end
      StyleRecvStall: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      StyleBoth:      begin send_idle_pct = 33; recv_stall_pct = 33; end
      default:        begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    cfg_write(RegPatternMode, mode_wd);
    cfg_write(RegLevel, level_wd);
    cfg_idle();
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        // drain mid-frame, then poke an unlisted index: scan must not move
        end_burst();
        cfg_write(RegUnusedLo + CfgIdxW'($urandom_range(1)), CfgDataW'($urandom));
        cfg_idle();
      end
      send_pixel($urandom_range(39) == 0);
    end
    end_burst();
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = RegPatternMode;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    restart_i      = 1'b0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset settings: carpet, one level; restart mid-frame, then a full frame
    for (int i = 0; i < 16; i++) send_pixel(i == 6);
    end_burst();

    // unused mode falls back to carpet, level zero acts as one
    cfg_write(RegPatternMode, {1'b1, ModeUnused});
    cfg_write(RegLevel, 3'd0);
    cfg_idle();
    for (int i = 0; i < 9; i++) send_pixel(i == 5);
    end_burst();

    // random bursts across patterns, levels and idle mixes
    run_phase({1'b0, ModeCarpet},   3'd2, 120, StyleFree);
    run_phase({1'b0, ModeTriangle}, 3'd3, 100, StyleSendIdle);
    run_phase({1'b0, ModeVicsek},   3'd2, 100, StyleRecvStall);
    run_phase({1'b0, ModeTriangle}, 3'd6,  60, StyleBoth);
    run_phase({1'b0, ModeVicsek},   3'd7,  50, StyleFree);
    run_phase({1'b0, ModeTriangle}, 3'd1,  40, StyleSendIdle);
    run_phase({1'b1, ModeVicsek},   3'd1,  40, StyleRecvStall);
    run_phase({1'b1, ModeCarpet},   3'd3,  60, StyleBoth);
    run_phase({1'b0, ModeTriangle}, 3'd4,  60, StyleFree);
    run_phase({1'b0, ModeUnused},   3'd0,  40, StyleSendIdle);
    run_phase({1'b0, ModeTriangle}, 3'd2,  60, StyleRecvStall);
    run_phase({1'b0, ModeVicsek},   3'd1,  40, StyleBoth);

    // catch any stray beat after the last one
    repeat (4) @(posedge clk_i);
    if (scan.errors == 0 && scan.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== fractal_raster_pixel_generator_top.f =====
rtl/frpg_pkg.sv
rtl/frpg_cell.sv
rtl/fractal_raster_pixel_generator_top.sv
dv/fractal_raster_pixel_generator_top_tb.sv
